@@ rtl/agm_pkg.sv @@
// Shared types and constants for the application-to-group map table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package agm_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 32;

    // operation codes
    localparam logic FN_LOOKUP = 1'b0;
    localparam logic FN_SET    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ADDED = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;     // capture request, restart scan
        logic scan;     // step the search
        logic finish;   // update table, load result register
    } cmd_t;

    typedef struct packed {
        logic match;    // compared entry equals request id
        logic scan_end; // all filled entries compared, no hit
        logic out_busy; // result register full and stalled
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/agm_ctrl.sv @@
// Controller state machine for the map table: sequences load, scan, finish.
// Depends on agm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agm_ctrl (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_stall,
    input  agm_pkg::sts_t sts,
    output agm_pkg::cmd_t cmd
);
    import agm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match || sts.scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/agm_datapath.sv @@
// Datapath: id/group memories, fill count, default register, scan
// compare pipeline and result register. Depends on agm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agm_datapath (
    input  wire                         clk,
    input  wire                         rst_n,
    input  agm_pkg::cmd_t               cmd,
    output agm_pkg::sts_t               sts,
    input  wire                         cfg_wr_en,
    input  wire  [agm_pkg::DATA_W-1:0]  cfg_wr_data,
    input  wire                         func,
    input  wire  [agm_pkg::DATA_W-1:0]  app_id,
    input  wire  [agm_pkg::DATA_W-1:0]  group_id,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [agm_pkg::DATA_W-1:0]  result_group,
    output logic                        found,
    output logic [1:0]                  status
);
    import agm_pkg::*;

    logic [DATA_W-1:0] id_mem  [ENTRIES];
    logic [DATA_W-1:0] grp_mem [ENTRIES];

    // control state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] dflt_reg;

    // payload
    logic              req_func_reg;
    logic [DATA_W-1:0] req_id_reg;
    logic [DATA_W-1:0] req_grp_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [DATA_W-1:0] hit_grp_reg;
    logic [DATA_W-1:0] id_q_reg;
    logic [DATA_W-1:0] grp_q_reg;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              found_reg, found_next;
    logic [1:0]        status_reg, status_next;

    logic              match;
    logic              issue;
    logic              wr_id_en;
    logic              wr_grp_en;
    logic [IDX_W-1:0]  wr_addr;

    assign match = cmp_valid_reg && (id_q_reg == req_id_reg);
    assign issue = cmd.scan && (cnt_reg < count_reg) && !match;

    assign sts.match    = match;
    assign sts.scan_end = (cnt_reg >= count_reg) && !cmp_valid_reg;
    assign sts.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        cnt_next       = cnt_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        wr_id_en       = 1'b0;
        wr_grp_en      = 1'b0;
        wr_addr        = slot_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            cnt_next       = '0;
            cmp_valid_next = 1'b0;
            hit_next       = 1'b0;
        end

        if (cmd.scan)
        begin
            cmp_valid_next = issue;
            if (issue)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (match)
            begin
                hit_next = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            res_next       = '0;
            found_next     = 1'b0;
            status_next    = ST_DONE;
            if (req_func_reg == FN_LOOKUP)
            begin
                res_next   = hit_reg ? hit_grp_reg : dflt_reg;
                found_next = hit_reg;
            end
            else if (req_id_reg == '0)
            begin
                status_next = ST_ZERO;
            end
            else if (hit_reg)
            begin
                wr_grp_en  = 1'b1;
                res_next   = req_grp_reg;
                found_next = 1'b1;
            end
            else if (count_reg < CNT_W'(ENTRIES))
            begin
                wr_id_en    = 1'b1;
                wr_grp_en   = 1'b1;
                wr_addr     = count_reg[IDX_W-1:0];
                count_next  = count_reg + 1'b1;
                res_next    = req_grp_reg;
                status_next = ST_ADDED;
            end
            else
            begin
                status_next = ST_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            dflt_reg      <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                dflt_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        if (cmd.load)
        begin
            req_func_reg <= func;
            req_id_reg   <= app_id;
            req_grp_reg  <= group_id;
        end
        if (cmd.scan && match)
        begin
            slot_reg    <= cmp_idx_reg;
            hit_grp_reg <= grp_q_reg;
        end
        if (issue)
        begin
            cmp_idx_reg <= cnt_reg[IDX_W-1:0];
        end
    end

    // both stores read at the scan address, one entry per cycle
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            id_q_reg  <= id_mem[cnt_reg[IDX_W-1:0]];
            grp_q_reg <= grp_mem[cnt_reg[IDX_W-1:0]];
        end
        if (wr_id_en)
        begin
            id_mem[wr_addr] <= req_id_reg;
        end
        if (wr_grp_en)
        begin
            grp_mem[wr_addr] <= req_grp_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_group = res_reg;
    assign found        = found_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

@@ rtl/app_to_group_map_table.sv @@
// Top level of the application-to-group map table: controller plus datapath.
// Depends on agm_pkg, agm_ctrl, agm_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  func, app_id, group_id
//   out      output     out_valid/out_stall  result_group, found, status
//   cfg      input      cfg_wr_en            cfg_wr_data (default_group)
//
// A miss compares all N filled entries and a hit ends the scan at the Kth entry:
// one id read per cycle while scanning, stop at first match.
// Requests are taken one at a time; the next is accepted the cycle after the
// result register loads, even while that result stalls; a stalled result holds
// the finishing request until the register frees.
// Reset empties the table at once through the fill count; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module app_to_group_map_table (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire  [agm_pkg::DATA_W-1:0]  cfg_wr_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire                         func,
    input  wire  [agm_pkg::DATA_W-1:0]  app_id,
    input  wire  [agm_pkg::DATA_W-1:0]  group_id,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [agm_pkg::DATA_W-1:0]  result_group,
    output logic                        found,
    output logic [1:0]                  status
);
    import agm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    agm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    agm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .func         (func),
        .app_id       (app_id),
        .group_id     (group_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_group (result_group),
        .found        (found),
        .status       (status)
    );

endmodule

`default_nettype wire

@@ rtl/agm_checker.sv @@
// Port-level assertions for the map table, bound to the top level.
// Depends on agm_pkg and app_to_group_map_table.
`timescale 1ns / 1ps
`default_nettype none

module agm_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_stall,
    input wire                         out_valid,
    input wire                         out_stall,
    input wire [agm_pkg::DATA_W-1:0]   result_group,
    input wire                         found,
    input wire [1:0]                   status
);
    import agm_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in flight");

    // rejected sets report nothing
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ZERO || status == ST_FULL)
        |-> (result_group == '0) && !found)
        else $error("rejected set carries data");

    // a hit never appends
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_DONE)
        else $error("found with non-done status");

endmodule

bind app_to_group_map_table agm_checker u_agm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_group (result_group),
    .found        (found),
    .status       (status)
);

`default_nettype wire
